[hw/rtl/length_prefixed_request_parser_defines.svh]
// Assertion macros for the checker file.
`ifndef LENGTH_PREFIXED_REQUEST_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_REQUEST_PARSER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LPRP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define LPRP_ASSERT(label, prop, msg) \
  `LPRP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/lprp_pkg.sv]
package lprp_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MESSAGE_BYTES = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_STRINGS       = 2'd1;

  localparam int unsigned MAX_MSG_BITS = 27;
  localparam int unsigned MAX_STR_BITS = 21;
  localparam int unsigned DONE_BITS    = 21;
  localparam int unsigned WORD_BITS    = 32;

  localparam logic [MAX_MSG_BITS-1:0] MAX_MSG_RESET = 27'd33554432;
  localparam logic [MAX_STR_BITS-1:0] MAX_STR_RESET = 21'd200000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_TOO_LONG  = 3'd2,
    STATUS_TOO_MANY  = 3'd3,
    STATUS_TRUNCATED = 3'd4,
    STATUS_TRAILING  = 3'd5
  } status_e;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       string_end;
    logic       empty_string;
    logic       message_done;
    status_e    status;
  } lprp_flags_t;

endpackage

[hw/rtl/lprp_if.sv]
interface lprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lprp_res_if #(
  parameter int unsigned INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic                  payload_valid;
  logic [7:0]            payload_byte;
  logic [INDEX_BITS-1:0] string_index;
  logic                  string_end;
  logic                  empty_string;
  logic                  message_done;
  logic [2:0]            status;

  modport source (
    output valid, payload_valid, payload_byte, string_index, string_end, empty_string,
           message_done, status,
    input  ready
  );
  modport sink (
    input  valid, payload_valid, payload_byte, string_index, string_end, empty_string,
           message_done, status,
    output ready
  );
endinterface

interface lprp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lprp_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lprp_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/length_prefixed_request_parser.sv]
// Channel  Modport  Carries                                        Handshake
// in_i     sink     data_byte, last_byte                           valid/ready
// cfg_i    sink     index, data (0 max_message_bytes, 1 max_strings) valid/ready
// out_o    source   payload_valid .. status, one item per input    valid/ready
//
// One input item is taken per cycle while the queue has room; each gives a result item.
// The parser register update in the front stage sets the one-item-per-cycle rate.
// A two-entry queue and an output register let input and output stall separately.
// Reset clears the parse state and loads the register defaults; cfg_i is always ready.
module length_prefixed_request_parser #(
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned COUNT_BITS = 27
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lprp_byte_if.sink  in_i,
  lprp_cfg_if.sink   cfg_i,
  lprp_res_if.source out_o
);

  localparam int unsigned FLAG_BITS  = $bits(lprp_pkg::lprp_flags_t);
  localparam int unsigned ENTRY_BITS = FLAG_BITS + INDEX_BITS;

  logic                  push;
  logic                  push_ready;
  lprp_pkg::lprp_flags_t front_flags;
  logic [INDEX_BITS-1:0] front_index;
  logic                  q_valid;
  logic                  q_pop;
  logic [ENTRY_BITS-1:0] q_data;
  lprp_pkg::lprp_flags_t q_flags;
  logic [INDEX_BITS-1:0] q_index;

  lprp_front #(
    .INDEX_BITS(INDEX_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .push_o      (push),
    .flags_o     (front_flags),
    .index_o     (front_index),
    .push_ready_i(push_ready)
  );

  lprp_fifo #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(lprp_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({front_flags, front_index}),
    .push_ready_o(push_ready),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (q_pop)
  );

  assign q_flags = lprp_pkg::lprp_flags_t'(q_data[ENTRY_BITS-1:INDEX_BITS]);
  assign q_index = q_data[INDEX_BITS-1:0];

  lprp_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_flags_i(q_flags),
    .q_index_i(q_index),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule

[hw/rtl/lprp_fifo.sv]
module lprp_fifo #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_i
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    entry_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/lprp_front.sv]
module lprp_front #(
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned COUNT_BITS = 27
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lprp_byte_if.sink             in_i,
  lprp_cfg_if.sink              cfg_i,
  output logic                  push_o,
  output lprp_pkg::lprp_flags_t flags_o,
  output logic [INDEX_BITS-1:0] index_o,
  input  logic                  push_ready_i
);

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_FIN   = 2'd3;

  localparam int unsigned CMP_BITS =
      (COUNT_BITS > lprp_pkg::MAX_MSG_BITS) ? COUNT_BITS : lprp_pkg::MAX_MSG_BITS;
  localparam int unsigned WB = lprp_pkg::WORD_BITS;

  logic [lprp_pkg::MAX_MSG_BITS-1:0] max_msg_q;
  logic [lprp_pkg::MAX_STR_BITS-1:0] max_str_q;

  logic [1:0]                     phase_q, phase_d;
  logic [COUNT_BITS-1:0]          count_q, count_d;
  logic [1:0]                     pos_q, pos_d;
  logic [23:0]                    acc_q, acc_d;
  logic [WB-1:0]                  expected_q, expected_d;
  logic [lprp_pkg::DONE_BITS-1:0] done_q, done_d;
  logic [WB-1:0]                  left_q, left_d;
  lprp_pkg::status_e              err_q, err_d;

  logic [WB-1:0]                  word;
  logic [lprp_pkg::DONE_BITS-1:0] done_inc;
  logic [WB-1:0]                  left_dec;
  logic                           accept;
  lprp_pkg::lprp_flags_t          flags;
  logic [INDEX_BITS-1:0]          index;

  assign accept      = in_i.valid & push_ready_i;
  assign in_i.ready  = push_ready_i;
  assign cfg_i.ready = 1'b1;
  assign push_o      = accept;
  assign flags_o     = flags;
  assign index_o     = index;

  assign word     = {in_i.data_byte, acc_q};
  assign done_inc = done_q + 1'b1;
  assign left_dec = left_q - 1'b1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    expected_d = expected_q;
    done_d     = done_q;
    left_d     = left_q;
    err_d      = err_q;
    flags      = '0;
    index      = '0;

    unique case (phase_q) inside
      PH_COUNT, PH_LEN: begin
        if (pos_q == 2'd3) begin
          pos_d = '0;
          if (phase_q == PH_COUNT) begin
            expected_d = word;
            if (word > WB'(max_str_q)) begin
              err_d   = lprp_pkg::STATUS_TOO_MANY;
              phase_d = PH_FIN;
            end else begin
              phase_d = (word == '0) ? PH_FIN : PH_LEN;
            end
          end else if (word == '0) begin
            flags.empty_string = 1'b1;
            index              = INDEX_BITS'(done_q);
            done_d             = done_inc;
            phase_d            = (WB'(done_inc) == expected_q) ? PH_FIN : PH_LEN;
          end else begin
            left_d  = word;
            phase_d = PH_DATA;
          end
        end else begin
          pos_d = pos_q + 1'b1;
          case (pos_q)
            2'd0:    acc_d[7:0]   = in_i.data_byte;
            2'd1:    acc_d[15:8]  = in_i.data_byte;
            default: acc_d[23:16] = in_i.data_byte;
          endcase
        end
      end
      PH_DATA: begin
        flags.payload_valid = 1'b1;
        flags.payload_byte  = in_i.data_byte;
        index               = INDEX_BITS'(done_q);
        left_d              = left_dec;
        if (left_dec == '0) begin
          flags.string_end = 1'b1;
          done_d           = done_inc;
          phase_d          = (WB'(done_inc) == expected_q) ? PH_FIN : PH_LEN;
        end
      end
      PH_FIN: begin
        if (err_q == lprp_pkg::STATUS_OK) begin
          err_d = lprp_pkg::STATUS_TRAILING;
        end
      end
      default: begin
        phase_d = PH_FIN;
      end
    endcase

    flags.message_done = in_i.last_byte;
    if (in_i.last_byte) begin
      if (count_q < COUNT_BITS'(3)) begin
        flags.status = lprp_pkg::STATUS_SHORT;
      end else if (CMP_BITS'(count_q) >= CMP_BITS'(max_msg_q)) begin
        flags.status = lprp_pkg::STATUS_TOO_LONG;
      end else if (err_d != lprp_pkg::STATUS_OK) begin
        flags.status = err_d;
      end else if (phase_d != PH_FIN) begin
        flags.status = lprp_pkg::STATUS_TRUNCATED;
      end else begin
        flags.status = lprp_pkg::STATUS_OK;
      end
    end

    if (in_i.last_byte) begin
      count_d = '0;
    end else if (count_q != '1) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end

    // The last byte of a message leaves the parser ready for the next one.
    if (in_i.last_byte) begin
      phase_d    = PH_COUNT;
      pos_d      = '0;
      expected_d = '0;
      done_d     = '0;
      left_d     = '0;
      err_d      = lprp_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_COUNT;
      count_q    <= '0;
      pos_q      <= '0;
      acc_q      <= '0;
      expected_q <= '0;
      done_q     <= '0;
      left_q     <= '0;
      err_q      <= lprp_pkg::STATUS_OK;
    end else if (accept) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      expected_q <= expected_d;
      done_q     <= done_d;
      left_q     <= left_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= lprp_pkg::MAX_MSG_RESET;
      max_str_q <= lprp_pkg::MAX_STR_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == lprp_pkg::REG_MAX_MESSAGE_BYTES) begin
        max_msg_q <= cfg_i.data[lprp_pkg::MAX_MSG_BITS-1:0];
      end else if (cfg_i.index == lprp_pkg::REG_MAX_STRINGS) begin
        max_str_q <= cfg_i.data[lprp_pkg::MAX_STR_BITS-1:0];
      end
    end
  end

endmodule

[hw/rtl/lprp_back.sv]
module lprp_back #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  lprp_pkg::lprp_flags_t q_flags_i,
  input  logic [INDEX_BITS-1:0] q_index_i,
  output logic                  q_pop_o,
  lprp_res_if.source            out_o
);

  logic                  valid_q;
  lprp_pkg::lprp_flags_t flags_q;
  logic [INDEX_BITS-1:0] index_q;
  logic                  load;

  assign load    = q_valid_i & (~valid_q | out_o.ready);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q <= q_flags_i;
      index_q <= q_index_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.payload_valid = flags_q.payload_valid;
  assign out_o.payload_byte  = flags_q.payload_byte;
  assign out_o.string_index  = index_q;
  assign out_o.string_end    = flags_q.string_end;
  assign out_o.empty_string  = flags_q.empty_string;
  assign out_o.message_done  = flags_q.message_done;
  assign out_o.status        = flags_q.status;

endmodule

[hw/rtl/lprp_checker.sv]
`include "length_prefixed_request_parser_defines.svh"

module lprp_checker #(
  parameter int unsigned INDEX_BITS = 20
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_payload_valid_i,
  input logic [7:0]            out_payload_byte_i,
  input logic [INDEX_BITS-1:0] out_string_index_i,
  input logic                  out_string_end_i,
  input logic                  out_empty_string_i,
  input logic                  out_message_done_i,
  input logic [2:0]            out_status_i
);

  `LPRP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_byte_i) && $stable(out_string_index_i) && $stable(out_status_i), "Stalled output item changed.")
  `LPRP_ASSERT(a_byte_zero, out_valid_i && !out_payload_valid_i |-> out_payload_byte_i == 8'd0, "Payload byte set without content.")
  `LPRP_ASSERT(a_status_done, out_valid_i && !out_message_done_i |-> out_status_i == lprp_pkg::STATUS_OK, "Status reported before the last byte.")
  `LPRP_ASSERT(a_end_content, out_valid_i && (out_string_end_i || out_empty_string_i) |-> out_payload_valid_i != out_empty_string_i, "String end marks disagree with content.")

endmodule

bind length_prefixed_request_parser lprp_checker #(
  .INDEX_BITS(INDEX_BITS)
) u_lprp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_payload_valid_i(out_o.payload_valid),
  .out_payload_byte_i (out_o.payload_byte),
  .out_string_index_i (out_o.string_index),
  .out_string_end_i   (out_o.string_end),
  .out_empty_string_i (out_o.empty_string),
  .out_message_done_i (out_o.message_done),
  .out_status_i       (out_o.status)
);

[dv/tb_length_prefixed_request_parser.sv]
module tb_length_prefixed_request_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W        = 20;
  localparam int unsigned COUNT_W      = 27;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PHASE_BYTES  = 200;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_LENGTH,
    PH_CONTENT,
    PH_FINISHED
  } parse_phase_e;

  typedef struct packed {
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic [IDX_W-1:0]  string_index;
    logic              string_end;
    logic              empty_string;
    logic              message_done;
    lprp_pkg::status_e status;
  } parse_result_t;

  class parse_scoreboard;
    parse_result_t                          parsed_items[$];
    int unsigned                            failures;
    logic [lprp_pkg::MAX_MSG_BITS-1:0]      max_msg;
    logic [lprp_pkg::MAX_STR_BITS-1:0]      max_str;
    parse_phase_e                           ph;
    logic [COUNT_W-1:0]                     byte_count;
    logic [1:0]                             word_pos;
    logic [lprp_pkg::WORD_BITS-1:0]         word_acc;
    logic [lprp_pkg::WORD_BITS-1:0]         strings_expected;
    logic [lprp_pkg::WORD_BITS-1:0]         bytes_left;
    logic [lprp_pkg::DONE_BITS-1:0]         strings_done;
    lprp_pkg::status_e                      err;

    function new();
      failures = 0;
      max_msg  = lprp_pkg::MAX_MSG_RESET;
      max_str  = lprp_pkg::MAX_STR_RESET;
      clear_parse();
    endfunction

    function void clear_parse();
      ph               = PH_COUNT;
      byte_count       = '0;
      word_pos         = '0;
      word_acc         = '0;
      strings_expected = '0;
      strings_done     = '0;
      bytes_left       = '0;
      err              = lprp_pkg::STATUS_OK;
    endfunction

    function void close_string();
      strings_done = strings_done + 1'b1;
      ph = ({11'b0, strings_done} == strings_expected) ? PH_FINISHED : PH_LENGTH;
    endfunction

    function void write_reg(logic [lprp_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [lprp_pkg::CFG_DATA_BITS-1:0] val);
      if (idx == lprp_pkg::REG_MAX_MESSAGE_BYTES) begin
        max_msg = val[lprp_pkg::MAX_MSG_BITS-1:0];
      end else if (idx == lprp_pkg::REG_MAX_STRINGS) begin
        max_str = val[lprp_pkg::MAX_STR_BITS-1:0];
      end
    endfunction

    function parse_result_t parse_byte(logic [7:0] b, logic l);
      parse_result_t r;
      logic [lprp_pkg::WORD_BITS-1:0] w;
      r = '0;
      r.status = lprp_pkg::STATUS_OK;
      if (ph == PH_COUNT || ph == PH_LENGTH) begin
        word_acc = word_acc | ({24'b0, b} << (8 * word_pos));
        if (word_pos == 2'd3) begin
          w        = word_acc;
          word_pos = '0;
          word_acc = '0;
          if (ph == PH_COUNT) begin
            strings_expected = w;
            if (w > {11'b0, max_str}) begin
              err = lprp_pkg::STATUS_TOO_MANY;
              ph  = PH_FINISHED;
            end else begin
              ph = (w == '0) ? PH_FINISHED : PH_LENGTH;
            end
          end else if (w == '0) begin
            r.empty_string = 1'b1;
            r.string_index = strings_done[IDX_W-1:0];
            close_string();
          end else begin
            bytes_left = w;
            ph         = PH_CONTENT;
          end
        end else begin
          word_pos = word_pos + 2'd1;
        end
      end else if (ph == PH_CONTENT) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.string_index  = strings_done[IDX_W-1:0];
        bytes_left      = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          r.string_end = 1'b1;
          close_string();
        end
      end else if (err == lprp_pkg::STATUS_OK) begin
        err = lprp_pkg::STATUS_TRAILING;
      end

      if (l) begin
        r.message_done = 1'b1;
        if (byte_count < 3) begin
          r.status = lprp_pkg::STATUS_SHORT;
        end else if (byte_count >= max_msg) begin
          r.status = lprp_pkg::STATUS_TOO_LONG;
        end else if (err != lprp_pkg::STATUS_OK) begin
          r.status = err;
        end else if (ph != PH_FINISHED) begin
          r.status = lprp_pkg::STATUS_TRUNCATED;
        end else begin
          r.status = lprp_pkg::STATUS_OK;
        end
        clear_parse();
      end else if (byte_count != '1) begin
        byte_count = byte_count + 1'b1;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      parsed_items.insert(parsed_items.size(), parse_byte(b, l));
    endfunction

    function void match(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(parse_result_t act);
      parse_result_t exp;
      if (parsed_items.size() == 0) begin
        $error("result item arrived with no byte waiting for it");
        failures++;
      end else begin
        exp = parsed_items.pop_front();
        match("payload_valid", 32'(exp.payload_valid), 32'(act.payload_valid));
        match("payload_byte", 32'(exp.payload_byte), 32'(act.payload_byte));
        match("string_index", 32'(exp.string_index), 32'(act.string_index));
        match("string_end", 32'(exp.string_end), 32'(act.string_end));
        match("empty_string", 32'(exp.empty_string), 32'(act.empty_string));
        match("message_done", 32'(exp.message_done), 32'(act.message_done));
        match("status", 32'(exp.status), 32'(act.status));
      end
    endfunction

    function int unsigned pending();
      return parsed_items.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lprp_byte_if                       in_if ();
  lprp_cfg_if                        cfg_if ();
  lprp_res_if #(.INDEX_BITS(IDX_W))  res_if ();

  length_prefixed_request_parser #(
    .INDEX_BITS(IDX_W),
    .COUNT_BITS(COUNT_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (res_if)
  );

  parse_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     quiet_cycles = 0;
  logic [7:0]      msg_q[$];

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void append_byte(logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  always @(posedge clk_i) begin
    res_if.ready <= !roll(recv_stall_pct);
  end

  always @(posedge clk_i) begin
    parse_result_t act;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.data_byte, in_if.last_byte);
      end
      if (res_if.valid && res_if.ready) begin
        act.payload_valid = res_if.payload_valid;
        act.payload_byte  = res_if.payload_byte;
        act.string_index  = res_if.string_index;
        act.string_end    = res_if.string_end;
        act.empty_string  = res_if.empty_string;
        act.message_done  = res_if.message_done;
        act.status        = lprp_pkg::status_e'(res_if.status);
        sb.check_result(act);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("** length_prefixed_request_parser: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (roll(send_idle_pct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lprp_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [lprp_pkg::CFG_DATA_BITS-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [lprp_pkg::CFG_DATA_BITS-1:0] msg_limit,
                           input logic [lprp_pkg::CFG_DATA_BITS-1:0] str_limit);
    write_reg(lprp_pkg::REG_MAX_MESSAGE_BYTES, msg_limit);
    write_reg(lprp_pkg::REG_MAX_STRINGS, str_limit);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      append_byte(w[8*i +: 8]);
    end
  endtask

  task automatic build_random_message();
    int unsigned kind;
    int unsigned cnt;
    int unsigned len;
    int unsigned cut;
    msg_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      cnt = $urandom_range(0, 4);
      push_word(cnt);
      for (int s = 0; s < cnt; s++) begin
        if (roll(25)) begin
          len = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(7, 24);
        end else begin
          len = $urandom_range(1, 6);
        end
        push_word(len);
        repeat (len) append_byte(8'($urandom));
      end
      if (kind >= 60 && kind < 70) begin
        repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
      end else if (kind >= 70) begin
        cut = $urandom_range(1, msg_q.size() - 1);
        repeat (cut) void'(msg_q.pop_back());
      end
    end else if (kind < 88) begin
      push_word($urandom);
      repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
    end else if (kind < 94) begin
      push_word($urandom_range(1, 3));
      push_word($urandom | 32'h0100_0000);
      repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      build_random_message();
      sent += msg_q.size();
      send_message();
    end
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits, no idling on either side.
    msg_q = '{8'hFF};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_message();
    msg_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA};
    send_message();
    run_random(PHASE_BYTES);
    drain();

    // Tightest limits, sender mostly idle.
    configure(32'd4, 32'd0);
    send_idle_pct = 80;
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00};
    send_message();
    run_random(PHASE_BYTES);
    drain();

    // Widest limits, receiver mostly stalling.
    configure(32'd67108864, 32'd1048576);
    send_idle_pct  = 0;
    recv_stall_pct = 80;
    run_random(PHASE_BYTES);
    drain();

    // Small random limits, light idling on both sides.
    configure($urandom_range(8, 40), $urandom_range(1, 3));
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    run_random(PHASE_BYTES);
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** length_prefixed_request_parser: PASSED **");
    end else begin
      $display("** length_prefixed_request_parser: FAILED **");
    end
    $finish;
  end
endmodule
